// ===== rtl/core/pxo_pkg.sv =====
// ----------------------------------------------------------------------------
// pxo_pkg: shared types and constants for the permutation crossover child
// command/status structs between controller and datapath, letter source codes
// ----------------------------------------------------------------------------
package pxo_pkg;

    localparam int LETTER_W    = 5;
    localparam int LETTER_SPAN = 32;
    localparam int SOURCE_W    = 2;
    localparam int SEED_W      = 16;

    localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

    localparam logic [SOURCE_W-1:0] SRC_A    = 2'd0;
    localparam logic [SOURCE_W-1:0] SRC_B    = 2'd1;
    localparam logic [SOURCE_W-1:0] SRC_RAND = 2'd2;

    typedef struct packed {
        logic commit_parent;
        logic commit_draw;
        logic step_lfsr;
        logic load_seed;
    } t_cmd;

    typedef struct packed {
        logic parent_hit;
        logic draw_hit;
    } t_status;

endpackage

// ===== rtl/core/pxo_in_if.sv =====
// ----------------------------------------------------------------------------
// pxo_in_if: parent letter channel
// valid/ready handshake carrying both parents' letters for one position
// ----------------------------------------------------------------------------
interface pxo_in_if;
    logic                          valid;
    logic                          ready;
    logic [pxo_pkg::LETTER_W-1:0]  parent_a_letter;
    logic [pxo_pkg::LETTER_W-1:0]  parent_b_letter;

    modport source (output valid, output parent_a_letter, output parent_b_letter,
                    input ready);
    modport sink   (input valid, input parent_a_letter, input parent_b_letter,
                    output ready);
endinterface

// ===== rtl/core/pxo_out_if.sv =====
// ----------------------------------------------------------------------------
// pxo_out_if: child letter channel
// valid/ready handshake carrying the chosen letter, its source and last flag
// ----------------------------------------------------------------------------
interface pxo_out_if;
    logic                          valid;
    logic                          ready;
    logic [pxo_pkg::LETTER_W-1:0]  child_letter;
    logic [pxo_pkg::SOURCE_W-1:0]  letter_source;
    logic                          last_position;

    modport source (output valid, output child_letter, output letter_source,
                    output last_position, input ready);
    modport sink   (input valid, input child_letter, input letter_source,
                    input last_position, output ready);
endinterface

// ===== rtl/core/pxo_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pxo_cfg_if: configuration write channel
// valid/ready handshake carrying the random seed
// ----------------------------------------------------------------------------
interface pxo_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pxo_pkg::SEED_W-1:0]  random_seed;

    modport source (output valid, output random_seed, input ready);
    modport sink   (input valid, input random_seed, output ready);
endinterface

// ===== rtl/core/pxo_ctrl.sv =====
// ----------------------------------------------------------------------------
// pxo_ctrl: controller
// accepts items, sequences random draws, owns the output valid flag
// ----------------------------------------------------------------------------
module pxo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  pxo_pkg::t_status i_status,
    output pxo_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_commit;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_seed = i_cfg_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_status.parent_hit) begin
                        o_cmd.commit_parent = 1'b1;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_DRAW: begin
                o_cmd.step_lfsr = 1'b1;
                if (i_status.draw_hit) begin
                    o_cmd.commit_draw = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_commit = o_cmd.commit_parent || o_cmd.commit_draw;

    always_comb begin
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // draw phase never takes a new item
    a_draw_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> !o_in_ready)
        else $error("item accepted during draw");

    // parent commit only on an accepted item
    a_parent_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit_parent |-> w_accept)
        else $error("parent commit without accepted item");

    // every commit shows a result next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule

// ===== rtl/core/pxo_datapath.sv =====
// ----------------------------------------------------------------------------
// pxo_datapath: datapath
// used-letter mask, parent counts, position, lfsr and output registers
// ----------------------------------------------------------------------------
module pxo_datapath #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pxo_pkg::t_cmd                    i_cmd,
    output pxo_pkg::t_status                 o_status,
    input  logic [pxo_pkg::LETTER_W-1:0]     i_parent_a_letter,
    input  logic [pxo_pkg::LETTER_W-1:0]     i_parent_b_letter,
    input  logic [pxo_pkg::SEED_W-1:0]       i_random_seed,
    output logic [pxo_pkg::LETTER_W-1:0]     o_child_letter,
    output logic [pxo_pkg::SOURCE_W-1:0]     o_letter_source,
    output logic                             o_last_position
);

    localparam int LW   = pxo_pkg::LETTER_W;
    localparam int SPAN = pxo_pkg::LETTER_SPAN;
    localparam int SW   = pxo_pkg::SEED_W;
    localparam logic [LW-1:0]            LAST_POS = LW'(ALPHABET_SIZE - 1);
    localparam logic [ALPHABET_SIZE-1:0] BIT0     = ALPHABET_SIZE'(1);

    logic [ALPHABET_SIZE-1:0]     r_used;
    logic [ALPHABET_SIZE-1:0]     n_used;
    logic [LW-1:0]                r_cnt_a;
    logic [LW-1:0]                n_cnt_a;
    logic [LW-1:0]                r_cnt_b;
    logic [LW-1:0]                n_cnt_b;
    logic [LW-1:0]                r_pos;
    logic [LW-1:0]                n_pos;
    logic [SW-1:0]                r_lfsr;
    logic [SW-1:0]                n_lfsr;
    logic [LW-1:0]                r_letter;
    logic [pxo_pkg::SOURCE_W-1:0] r_source;
    logic                         r_last;

    logic [SPAN-1:0]              w_mask_full;
    logic                         w_b_first;
    logic [LW-1:0]                w_first;
    logic [LW-1:0]                w_second;
    logic                         w_first_free;
    logic                         w_second_free;
    logic [LW-1:0]                w_pick;
    logic [pxo_pkg::SOURCE_W-1:0] w_pick_src;
    logic [SW-1:0]                w_lfsr_step;
    logic                         w_commit;
    logic [LW-1:0]                w_letter;
    logic [pxo_pkg::SOURCE_W-1:0] w_source;
    logic                         w_last;

    // letters beyond the alphabet read as used
    if (ALPHABET_SIZE < SPAN) begin : g_pad
        assign w_mask_full = {{(SPAN - ALPHABET_SIZE){1'b1}}, r_used};
    end else begin : g_full
        assign w_mask_full = r_used;
    end

    assign w_b_first     = r_cnt_a > r_cnt_b;
    assign w_first       = w_b_first ? i_parent_b_letter : i_parent_a_letter;
    assign w_second      = w_b_first ? i_parent_a_letter : i_parent_b_letter;
    assign w_first_free  = !w_mask_full[w_first];
    assign w_second_free = !w_mask_full[w_second];

    always_comb begin
        if (w_first_free) begin
            w_pick     = w_first;
            w_pick_src = w_b_first ? pxo_pkg::SRC_B : pxo_pkg::SRC_A;
        end else begin
            w_pick     = w_second;
            w_pick_src = w_b_first ? pxo_pkg::SRC_A : pxo_pkg::SRC_B;
        end
    end

    // galois step, shift right
    assign w_lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? pxo_pkg::LFSR_TAPS : '0);

    assign o_status.parent_hit = w_first_free || w_second_free;
    assign o_status.draw_hit   = !w_mask_full[w_lfsr_step[LW-1:0]];

    assign w_commit = i_cmd.commit_parent || i_cmd.commit_draw;
    assign w_letter = i_cmd.commit_parent ? w_pick : w_lfsr_step[LW-1:0];
    assign w_source = i_cmd.commit_parent ? w_pick_src : pxo_pkg::SRC_RAND;
    assign w_last   = r_pos >= LAST_POS;

    always_comb begin
        n_used  = r_used;
        n_cnt_a = r_cnt_a;
        n_cnt_b = r_cnt_b;
        n_pos   = r_pos;
        if (w_commit) begin
            n_used = r_used | (BIT0 << w_letter);
            if (w_source == pxo_pkg::SRC_A) begin
                n_cnt_a = r_cnt_a + 1'b1;
            end
            if (w_source == pxo_pkg::SRC_B) begin
                n_cnt_b = r_cnt_b + 1'b1;
            end
            n_pos = r_pos + 1'b1;
            if (w_last) begin
                n_used  = '0;
                n_cnt_a = '0;
                n_cnt_b = '0;
                n_pos   = '0;
            end
        end
    end

    always_comb begin
        if (i_cmd.load_seed) begin
            n_lfsr = (i_random_seed == '0) ? SW'(1) : i_random_seed;
        end else if (i_cmd.step_lfsr) begin
            n_lfsr = w_lfsr_step;
        end else begin
            n_lfsr = r_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_pos   <= '0;
            r_lfsr  <= pxo_pkg::SEED_RESET;
        end else begin
            r_used  <= n_used;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_pos   <= n_pos;
            r_lfsr  <= n_lfsr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_letter <= w_letter;
            r_source <= w_source;
            r_last   <= w_last;
        end
    end

    assign o_child_letter  = r_letter;
    assign o_letter_source = r_source;
    assign o_last_position = r_last;

    // committed letter was free
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> !w_mask_full[w_letter])
        else $error("committed letter already used");

    // position stays inside the alphabet
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("position out of range");

    // one commit source at a time
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.commit_parent, i_cmd.commit_draw}))
        else $error("both commit sources active");

endmodule

// ===== rtl/core/permutation_crossover_child.sv =====
// ----------------------------------------------------------------------------
// permutation_crossover_child: builds a child permutation from two parents
//
// i_item carries both parents' letters for the next position; o_result
// returns the chosen child letter, its source (parent a, parent b, random)
// and a flag on the final position of the child. i_cfg writes the seed of
// the 16-bit lfsr used for random draws; a zero seed loads as one.
// When a parent letter is free the result is registered at the edge that
// takes the item: one item per cycle while the receiver takes each result.
// When both parent letters are used the block steps the lfsr once per
// cycle until a free letter shows in its low bits; no item is taken meanwhile.
// A result waiting on a stalled receiver holds in the output register; a new
// item is taken in the cycle the receiver takes that result.
// Reset clears the used-letter mask, counts and position and loads the lfsr
// with its default seed; after the last position of a child they clear again.
// ----------------------------------------------------------------------------
module permutation_crossover_child #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pxo_in_if.sink    i_item,
    pxo_out_if.source o_result,
    pxo_cfg_if.sink   i_cfg
);

    pxo_pkg::t_cmd    w_cmd;
    pxo_pkg::t_status w_status;

    pxo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    pxo_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_parent_a_letter (i_item.parent_a_letter),
        .i_parent_b_letter (i_item.parent_b_letter),
        .i_random_seed     (i_cfg.random_seed),
        .o_child_letter    (o_result.child_letter),
        .o_letter_source   (o_result.letter_source),
        .o_last_position   (o_result.last_position)
    );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for permutation_crossover_child
// feeds directed parent letter pairs, then pairs from whole random permutations, corrupted
// permutations and raw noise, under several lfsr seeds, with random sender
// bursts and receiver stalls; an in-bench model of the letter choice and the
// lfsr draws predicts every child letter and checks it field by field
// ----------------------------------------------------------------------------
module tb;

    localparam int ALPHABET    = 26;
    localparam int LFSR_PERIOD = 65535;
    localparam int STALL_LIMIT = 300000;
    localparam int LW          = pxo_pkg::LETTER_W;
    localparam int SRCW        = pxo_pkg::SOURCE_W;
    localparam int SDW         = pxo_pkg::SEED_W;

    typedef struct packed {
        logic [LW-1:0] a;
        logic [LW-1:0] b;
    } t_parent_pair;

    typedef struct packed {
        logic [LW-1:0]   letter;
        logic [SRCW-1:0] source;
        logic            last;
    } t_child_result;

    typedef logic [LW-1:0] t_letter_row [ALPHABET];

    logic i_clk = 1'b0;
    logic i_rst_n;

    pxo_in_if  item_if ();
    pxo_out_if result_if ();
    pxo_cfg_if cfg_if ();

    permutation_crossover_child #(
        .ALPHABET_SIZE(ALPHABET)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // child builder model state
    logic [ALPHABET-1:0] used_mask;
    logic [LW-1:0]       taken_from_a;
    logic [LW-1:0]       taken_from_b;
    logic [LW-1:0]       child_pos;
    logic [SDW-1:0]      draw_lfsr;

    t_parent_pair  pending_pairs[$];
    t_child_result expected_letters[$];
    int            next_pos;
    int            fail_count;
    int            stall_cycles;
    int            ready_mode;
    logic [11:0]   stall_pattern;
    logic          item_taken;
    int            burst_left;
    int            idle_left;

    t_parent_pair directed_pairs [15] = '{
        {5'd0,  5'd0},  {5'd0,  5'd1},  {5'd0,  5'd1},  {5'd31, 5'd31},
        {5'd26, 5'd27}, {5'd2,  5'd3},  {5'd2,  5'd3},  {5'd25, 5'd3},
        {5'd30, 5'd24}, {5'd16, 5'd8},  {5'd31, 5'd8},  {5'd15, 5'd31},
        {5'd15, 5'd29}, {5'd21, 5'd10}, {5'd21, 5'd10}
    };

    function automatic logic letter_free(input logic [LW-1:0] l);
        return (l < ALPHABET) ? !used_mask[l] : 1'b0;
    endfunction

    function automatic void clear_child();
        used_mask    = '0;
        taken_from_a = '0;
        taken_from_b = '0;
        child_pos    = '0;
    endfunction

    function automatic t_child_result place_letter(input logic [LW-1:0] a,
                                                   input logic [LW-1:0] b);
        t_child_result res;
        logic          b_first;
        logic          found;
        logic          shifted_out;
        logic [LW-1:0] first;
        logic [LW-1:0] second;
        res.letter = '0;
        res.source = pxo_pkg::SRC_RAND;
        res.last   = 1'b0;
        b_first    = taken_from_a > taken_from_b;
        first      = b_first ? b : a;
        second     = b_first ? a : b;
        if (letter_free(first)) begin
            res.letter = first;
            res.source = b_first ? pxo_pkg::SRC_B : pxo_pkg::SRC_A;
        end else if (letter_free(second)) begin
            res.letter = second;
            res.source = b_first ? pxo_pkg::SRC_A : pxo_pkg::SRC_B;
        end else begin
            found = 1'b0;
            for (int n = 0; n < LFSR_PERIOD && !found; n++) begin
                shifted_out = draw_lfsr[0];
                draw_lfsr   = draw_lfsr >> 1;
                if (shifted_out)
                    draw_lfsr = draw_lfsr ^ pxo_pkg::LFSR_TAPS;
                if (letter_free(draw_lfsr[LW-1:0])) begin
                    res.letter = draw_lfsr[LW-1:0];
                    found      = 1'b1;
                end
            end
            // lowest free letter if the draws never hit
            for (int k = 0; k < ALPHABET && !found; k++) begin
                if (letter_free(LW'(k))) begin
                    res.letter = LW'(k);
                    found      = 1'b1;
                end
            end
        end
        if (res.letter < ALPHABET)
            used_mask[res.letter] = 1'b1;
        if (res.source == pxo_pkg::SRC_A)
            taken_from_a = taken_from_a + 1'b1;
        else if (res.source == pxo_pkg::SRC_B)
            taken_from_b = taken_from_b + 1'b1;
        if (child_pos >= ALPHABET - 1) begin
            res.last = 1'b1;
            clear_child();
        end else begin
            child_pos = child_pos + 1'b1;
        end
        return res;
    endfunction

    function automatic t_letter_row shuffled_alphabet();
        t_letter_row   row;
        int            j;
        logic [LW-1:0] t;
        for (int i = 0; i < ALPHABET; i++)
            row[i] = LW'(i);
        for (int i = ALPHABET - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            t      = row[i];
            row[i] = row[j];
            row[j] = t;
        end
        return row;
    endfunction

    task automatic queue_pair(input logic [LW-1:0] a, input logic [LW-1:0] b);
        t_parent_pair pair;
        pair.a = a;
        pair.b = b;
        pending_pairs.push_back(pair);
        next_pos = (next_pos + 1) % ALPHABET;
    endtask

    // parents for the rest of the current child: clean, corrupted or noise
    task automatic queue_child();
        t_letter_row   parent_a;
        t_letter_row   parent_b;
        int            kind;
        int            start;
        logic [LW-1:0] a;
        logic [LW-1:0] b;
        parent_a = shuffled_alphabet();
        parent_b = shuffled_alphabet();
        kind     = $urandom_range(0, 99);
        start    = next_pos;
        for (int p = start; p < ALPHABET; p++) begin
            a = parent_a[p];
            b = parent_b[p];
            if (kind >= 85) begin
                a = LW'($urandom_range(0, 31));
                b = ($urandom_range(0, 3) == 0) ? a : LW'($urandom_range(0, 31));
            end else if (kind >= 70) begin
                if ($urandom_range(0, 4) == 0)
                    a = LW'($urandom_range(0, 31));
                if ($urandom_range(0, 4) == 0)
                    b = LW'($urandom_range(0, 31));
            end
            queue_pair(a, b);
        end
    endtask

    task automatic load_seed(input logic [SDW-1:0] value);
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.random_seed <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        draw_lfsr = (value == '0) ? SDW'(1) : value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_letters.size() != 0 || item_if.valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            burst_left    <= 1;
            idle_left     <= 0;
        end else if (!item_if.valid || item_taken) begin
            if (idle_left > 0) begin
                item_if.valid <= 1'b0;
                idle_left     <= idle_left - 1;
            end else if (pending_pairs.size() != 0) begin
                item_if.parent_a_letter <= pending_pairs[0].a;
                item_if.parent_b_letter <= pending_pairs[0].b;
                void'(pending_pairs.pop_front());
                item_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // receiver: always ready, random stalls or a rotating stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            stall_pattern <= {stall_pattern[10:0], stall_pattern[11]};
            case (ready_mode)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= ($urandom_range(0, 3) != 0);
                default: result_if.ready <= stall_pattern[0];
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_child_result want;
        item_taken <= item_if.valid && item_if.ready;
        if (i_rst_n && item_if.valid && item_if.ready)
            expected_letters.push_back(place_letter(item_if.parent_a_letter,
                                                    item_if.parent_b_letter));
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_letters.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %0d/%0d/%0d",
                         $time, result_if.child_letter, result_if.letter_source,
                         result_if.last_position);
                fail_count++;
            end else begin
                want = expected_letters.pop_front();
                if (result_if.child_letter !== want.letter) begin
                    $display("%0t: child_letter mismatch: expected %0d, actual %0d",
                             $time, want.letter, result_if.child_letter);
                    fail_count++;
                end
                if (result_if.letter_source !== want.source) begin
                    $display("%0t: letter_source mismatch: expected %0d, actual %0d",
                             $time, want.source, result_if.letter_source);
                    fail_count++;
                end
                if (result_if.last_position !== want.last) begin
                    $display("%0t: last_position mismatch: expected %0d, actual %0d",
                             $time, want.last, result_if.last_position);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [SDW-1:0] phase_seed;
        item_if.valid           = 1'b0;
        item_if.parent_a_letter = '0;
        item_if.parent_b_letter = '0;
        result_if.ready         = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.random_seed      = '0;
        i_rst_n                 = 1'b0;
        item_taken              = 1'b0;
        fail_count              = 0;
        stall_cycles            = 0;
        next_pos                = 0;
        ready_mode              = 0;
        stall_pattern           = 12'b1101_1110_0111;
        clear_child();
        draw_lfsr = pxo_pkg::SEED_RESET;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset seed: directed cases, then the rest of that child and two more
        foreach (directed_pairs[i])
            queue_pair(directed_pairs[i].a, directed_pairs[i].b);
        repeat (3) queue_child();
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       phase_seed = 16'd1;
                1:       phase_seed = 16'hFFFF;
                2:       phase_seed = 16'd0;
                5:       phase_seed = pxo_pkg::SEED_RESET;
                default: phase_seed = SDW'($urandom_range(1, 65535));
            endcase
            load_seed(phase_seed);
            ready_mode    = (phase + 1) % 3;
            stall_pattern = 12'($urandom_range(0, 4095)) | 12'h001;
            repeat (2) queue_child();
            wait_drained();
        end

        if (fail_count == 0 && expected_letters.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
